### design/uhts_pkg.sv
// ----------------------------------------------------------------------------
// uhts_pkg
// Shared types and codes of the USB host transaction sequencer.
// ----------------------------------------------------------------------------
package uhts_pkg;

    // opcodes carried in tuser
    typedef enum logic [2:0] {
        OP_PORT_RESET = 3'd0,
        OP_PULLUP     = 3'd1,
        OP_FRAME      = 3'd2,
        OP_XFER       = 3'd3,
        OP_SETUP      = 3'd4,
        OP_RESULT     = 3'd5
    } t_op;

    // bus handshake or data pid seen by the transaction engine
    typedef enum logic [2:0] {
        EV_STALL = 3'd0,
        EV_ACK   = 3'd1,
        EV_NAK   = 3'd2,
        EV_DATA0 = 3'd3,
        EV_DATA1 = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        RES_SUCCESS = 2'd0,
        RES_STALLED = 2'd1,
        RES_TIMEOUT = 2'd2
    } t_result;

    typedef enum logic [1:0] {
        PEV_NONE     = 2'd0,
        PEV_ATTACHED = 2'd1,
        PEV_REMOVED  = 2'd2
    } t_port_event;

    typedef enum logic [1:0] {
        BUS_QUIET = 2'd0,
        BUS_RESET = 2'd1,
        BUS_SOF   = 2'd2
    } t_bus_mode;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_MAX_PACKET  = 3'd0,
        CFG_TIMEOUT     = 3'd1,
        CFG_SETTLE      = 3'd2,
        CFG_RESET_FULL  = 3'd3,
        CFG_RESET_LOW   = 3'd4
    } t_cfg_idx;

    // bit positions in the transfer kind flags
    localparam int KIND_SETUP = 0;
    localparam int KIND_IN    = 1;
    localparam int KIND_OUT   = 2;

    localparam logic [9:0]  SETUP_LEN   = 10'd8;
    localparam logic [10:0] RX_COUNT_MAX = 11'd1025;
    localparam logic [10:0] CRC_BYTES   = 11'd2;

    typedef struct packed {
        logic [9:0] max_packet;
        logic [7:0] timeout_frames;
        logic [7:0] settle_frames;
        logic [8:0] reset_frames_full;
        logic [8:0] reset_frames_low;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  op;
        logic        pullup_present;
        logic        pullup_k;
        logic [10:0] sof_frame;
        logic        dir_in;
        logic [15:0] buf_len;
        logic [2:0]  event_kind;
        logic [10:0] rx_count;
    } t_item;

    typedef struct packed {
        logic        issue_cmd;
        logic        data_toggle;
        logic [15:0] chunk_offset;
        logic [9:0]  chunk_len;
        logic        complete;
        logic [1:0]  result_code;
        logic [15:0] xfer_length;
    } t_xfer_res;

    typedef struct packed {
        logic [1:0]  port_event;
        logic [1:0]  bus_state;
        logic        low_speed;
        logic [31:0] frame_cnt;
    } t_port_res;

endpackage

### design/uhts_port_ctrl.sv
// ----------------------------------------------------------------------------
// uhts_port_ctrl
// Root port control: attach settle count, bus reset length, port speed and
// the 32-bit frame counter.
// ----------------------------------------------------------------------------
module uhts_port_ctrl
    import uhts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_item     i_item,
    input  t_cfg      i_cfg,
    output logic      o_xfer_tick,
    output t_port_res o_res
);

    logic [7:0]  r_settle_left, n_settle_left;
    logic [8:0]  r_reset_left,  n_reset_left;
    logic        r_port_low,    n_port_low;
    logic [1:0]  r_bus_mode,    n_bus_mode;
    logic [31:0] r_frame_count, n_frame_count;
    logic [20:0] frame_high;
    logic [1:0]  port_event;

    // frame counter extension: carry into the upper bits on wrap of the low 11
    always_comb begin
        frame_high = r_frame_count[31:11];
        if (i_item.sof_frame < r_frame_count[10:0]) begin
            frame_high = r_frame_count[31:11] + 21'd1;
        end
    end

    // next state of the port
    always_comb begin
        n_settle_left = r_settle_left;
        n_reset_left  = r_reset_left;
        n_port_low    = r_port_low;
        n_bus_mode    = r_bus_mode;
        n_frame_count = r_frame_count;
        port_event    = PEV_NONE;
        o_xfer_tick   = 1'b0;
        case (i_item.op)
            OP_PORT_RESET: begin
                n_bus_mode   = BUS_RESET;
                n_reset_left = i_cfg.reset_frames_full;
            end
            OP_PULLUP: begin
                n_reset_left = '0;
                n_bus_mode   = BUS_QUIET;
                if (i_item.pullup_present || i_item.pullup_k) begin
                    n_settle_left = i_cfg.settle_frames;
                    if (i_item.pullup_k) begin
                        n_port_low = ~r_port_low;
                    end
                end else begin
                    n_settle_left = '0;
                    port_event    = PEV_REMOVED;
                end
            end
            OP_FRAME: begin
                n_frame_count = {frame_high, i_item.sof_frame};
                if (r_settle_left != '0) begin
                    n_settle_left = r_settle_left - 8'd1;
                    if (r_settle_left == 8'd1) begin
                        n_bus_mode   = BUS_RESET;
                        n_reset_left = r_port_low ? i_cfg.reset_frames_low
                                                  : i_cfg.reset_frames_full;
                        port_event   = PEV_ATTACHED;
                    end
                end else if (r_reset_left != '0) begin
                    n_reset_left = r_reset_left - 9'd1;
                    if (r_reset_left == 9'd1) begin
                        n_bus_mode = BUS_SOF;
                    end
                end else begin
                    o_xfer_tick = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // port state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_left <= '0;
            r_reset_left  <= '0;
            r_port_low    <= 1'b0;
            r_bus_mode    <= BUS_QUIET;
            r_frame_count <= '0;
        end else if (i_step) begin
            r_settle_left <= n_settle_left;
            r_reset_left  <= n_reset_left;
            r_port_low    <= n_port_low;
            r_bus_mode    <= n_bus_mode;
            r_frame_count <= n_frame_count;
        end
    end

    assign o_res.port_event = port_event;
    assign o_res.bus_state  = n_bus_mode;
    assign o_res.low_speed  = n_port_low;
    assign o_res.frame_cnt  = n_frame_count;

endmodule

### design/uhts_xfer_ctrl.sv
// ----------------------------------------------------------------------------
// uhts_xfer_ctrl
// Transfer engine: packet chunking, data toggle, nak retry, short packet
// detection and frame timeout.
// ----------------------------------------------------------------------------
module uhts_xfer_ctrl
    import uhts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_item     i_item,
    input  t_cfg      i_cfg,
    input  logic      i_xfer_tick,
    output t_xfer_res o_res
);

    logic        r_busy,      n_busy;
    logic [2:0]  r_kind,      n_kind;
    logic        r_toggle,    n_toggle;
    logic [15:0] r_in_rem,    n_in_rem;
    logic [15:0] r_out_rem,   n_out_rem;
    logic [15:0] r_position,  n_position;
    logic [15:0] r_done,      n_done;
    logic [7:0]  r_timeout,   n_timeout;
    logic        r_nak_retry, n_nak_retry;

    logic [15:0] mp16;
    logic [15:0] out_rem_next;
    logic [9:0]  out_chunk_cur;
    logic [9:0]  out_chunk_next;
    logic [9:0]  start_chunk;
    logic [10:0] rx_clamped;
    logic [9:0]  rx_payload;
    logic [15:0] kept;
    logic [15:0] in_rem_after;
    logic [15:0] done_after_in;
    logic        short_pkt;
    t_xfer_res   res;

    // chunk sizes and receive byte count
    always_comb begin
        mp16           = {6'd0, i_cfg.max_packet};
        out_rem_next   = r_out_rem - mp16;
        out_chunk_cur  = (r_out_rem > mp16) ? i_cfg.max_packet : r_out_rem[9:0];
        out_chunk_next = (out_rem_next > mp16) ? i_cfg.max_packet : out_rem_next[9:0];
        start_chunk    = (i_item.buf_len > mp16) ? i_cfg.max_packet
                                                 : i_item.buf_len[9:0];
        rx_clamped     = (i_item.rx_count > RX_COUNT_MAX) ? RX_COUNT_MAX : i_item.rx_count;
        rx_payload     = (rx_clamped >= CRC_BYTES) ? 10'(rx_clamped - CRC_BYTES) : 10'd0;
        kept           = ({6'd0, rx_payload} > r_in_rem) ? r_in_rem : {6'd0, rx_payload};
        in_rem_after   = r_in_rem - kept;
        done_after_in  = r_done + kept;
        short_pkt      = rx_clamped < ({1'b0, i_cfg.max_packet} + CRC_BYTES);
    end

    // transfer sequencing
    always_comb begin
        n_busy      = r_busy;
        n_kind      = r_kind;
        n_toggle    = r_toggle;
        n_in_rem    = r_in_rem;
        n_out_rem   = r_out_rem;
        n_position  = r_position;
        n_done      = r_done;
        n_timeout   = r_timeout;
        n_nak_retry = r_nak_retry;
        res         = '0;
        case (i_item.op)
            OP_PORT_RESET: begin
                n_busy      = 1'b0;
                n_nak_retry = 1'b0;
                n_in_rem    = '0;
                n_out_rem   = '0;
            end
            OP_FRAME: begin
                if (i_xfer_tick && r_busy) begin
                    if (r_nak_retry) begin
                        // reissue the stored transaction after a nak
                        res.issue_cmd   = 1'b1;
                        res.data_toggle = r_toggle;
                        if (r_kind[KIND_OUT]) begin
                            res.chunk_offset = r_position;
                            res.chunk_len    = out_chunk_cur;
                        end else if (r_kind[KIND_SETUP]) begin
                            res.chunk_len    = SETUP_LEN;
                        end
                        if (r_kind[KIND_IN]) begin
                            res.chunk_offset = r_position;
                            res.chunk_len    = '0;
                        end
                        n_nak_retry = 1'b0;
                        n_timeout   = i_cfg.timeout_frames;
                    end else begin
                        n_timeout = r_timeout - 8'd1;
                        if (r_timeout == 8'd1) begin
                            res.complete    = 1'b1;
                            res.result_code = RES_TIMEOUT;
                            res.xfer_length = r_done;
                            n_busy          = 1'b0;
                        end
                    end
                end
            end
            OP_XFER: begin
                n_busy          = 1'b1;
                n_position      = '0;
                n_done          = '0;
                n_timeout       = i_cfg.timeout_frames;
                n_nak_retry     = 1'b0;
                n_toggle        = 1'b1;
                res.issue_cmd   = 1'b1;
                res.data_toggle = 1'b1;
                if (i_item.dir_in) begin
                    n_kind    = 3'b1 << KIND_IN;
                    n_in_rem  = i_item.buf_len;
                    n_out_rem = '0;
                end else begin
                    n_kind        = 3'b1 << KIND_OUT;
                    n_out_rem     = i_item.buf_len;
                    n_in_rem      = '0;
                    res.chunk_len = start_chunk;
                end
            end
            OP_SETUP: begin
                n_busy        = 1'b1;
                n_position    = '0;
                n_done        = '0;
                n_timeout     = i_cfg.timeout_frames;
                n_nak_retry   = 1'b0;
                n_toggle      = 1'b0;
                n_kind        = 3'b1 << KIND_SETUP;
                n_in_rem      = '0;
                n_out_rem     = '0;
                res.issue_cmd = 1'b1;
                res.chunk_len = SETUP_LEN;
            end
            OP_RESULT: begin
                if (r_busy) begin
                    case (i_item.event_kind)
                        EV_STALL: begin
                            res.complete    = 1'b1;
                            res.result_code = RES_STALLED;
                            res.xfer_length = r_done;
                            n_busy          = 1'b0;
                            n_nak_retry     = 1'b0;
                        end
                        EV_ACK: begin
                            if (r_kind[KIND_OUT] && (r_out_rem > mp16)) begin
                                // next out chunk
                                n_out_rem        = out_rem_next;
                                n_position       = r_position + mp16;
                                n_done           = r_done + mp16;
                                n_toggle         = ~r_toggle;
                                res.issue_cmd    = 1'b1;
                                res.data_toggle  = ~r_toggle;
                                res.chunk_offset = r_position + mp16;
                                res.chunk_len    = out_chunk_next;
                            end else begin
                                res.complete    = 1'b1;
                                res.result_code = RES_SUCCESS;
                                if (r_kind[KIND_OUT]) begin
                                    n_done          = r_done + r_out_rem;
                                    res.xfer_length = r_done + r_out_rem;
                                end else begin
                                    res.xfer_length = r_done;
                                end
                                n_busy      = 1'b0;
                                n_nak_retry = 1'b0;
                            end
                        end
                        EV_NAK: begin
                            if (!r_kind[KIND_SETUP]) begin
                                n_nak_retry = 1'b1;
                            end
                        end
                        EV_DATA0, EV_DATA1: begin
                            if (r_kind[KIND_IN]) begin
                                res.chunk_offset = r_position;
                                res.chunk_len    = kept[9:0];
                                n_position       = r_position + kept;
                                n_in_rem         = in_rem_after;
                                n_done           = done_after_in;
                                if ((in_rem_after == '0) || short_pkt) begin
                                    res.complete    = 1'b1;
                                    res.result_code = RES_SUCCESS;
                                    res.xfer_length = done_after_in;
                                    n_busy          = 1'b0;
                                    n_nak_retry     = 1'b0;
                                end else begin
                                    n_toggle        = ~r_toggle;
                                    res.issue_cmd   = 1'b1;
                                    res.data_toggle = ~r_toggle;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // transfer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_kind      <= '0;
            r_toggle    <= 1'b1;
            r_in_rem    <= '0;
            r_out_rem   <= '0;
            r_position  <= '0;
            r_done      <= '0;
            r_timeout   <= '0;
            r_nak_retry <= 1'b0;
        end else if (i_step) begin
            r_busy      <= n_busy;
            r_kind      <= n_kind;
            r_toggle    <= n_toggle;
            r_in_rem    <= n_in_rem;
            r_out_rem   <= n_out_rem;
            r_position  <= n_position;
            r_done      <= n_done;
            r_timeout   <= n_timeout;
            r_nak_retry <= n_nak_retry;
        end
    end

    assign o_res = res;

endmodule

### design/usb_host_transaction_sequencer_top.sv
// ----------------------------------------------------------------------------
// usb_host_transaction_sequencer_top
// USB full/low speed host transfer sequencer with root port control.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                       payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   tuser op, tdata event fields
//  m_axis    out        m_axis_tvalid / m_axis_tready   tdata result fields
//  cfg       in         i_cfg_we                        i_cfg_idx, i_cfg_data
//
// Each request is captured in the input register, the step logic works on it,
// and its result is loaded into the result register when the output side can
// take it. One request is taken per cycle while the output is not stalled; the
// state update is a single pass of compares and adds.
// Reset is synchronous; it clears the pipeline valids, resets the sequencer
// state and loads the configuration defaults. A stalled output holds the
// result and input registers, and the input side stalls only once both are full.
// ----------------------------------------------------------------------------
module usb_host_transaction_sequencer_top
    import uhts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0: pullup_present, pullup_k, sof_frame[10:0], usb_addr[6:0],
    // ep_num[3:0], dir_in, buf_len[15:0], dev_low_speed, event_kind[2:0],
    // rx_count[10:0]
    input  logic [55:0] s_axis_tdata,
    // tuser: op[2:0]
    input  logic [2:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata from bit 0: issue_cmd, data_toggle, chunk_offset[15:0], chunk_len[9:0],
    // complete, result_code[1:0], xfer_length[15:0], port_event[1:0],
    // bus_state[1:0], low_speed, frame_cnt[31:0], zero fill
    output logic [87:0] m_axis_tdata,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [9:0]  i_cfg_data
);

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_item     r_in_item;
    logic      r_out_valid;
    logic [87:0] r_out_data;

    logic      out_ready;
    logic      step;
    logic      xfer_tick;
    t_item     item_in;
    t_xfer_res xfer_res;
    t_port_res port_res;

    // pipeline flow control
    assign out_ready     = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_ready;
    assign s_axis_tready = !r_in_valid || out_ready;

    // request field unpacking
    always_comb begin
        item_in.op             = s_axis_tuser;
        item_in.pullup_present = s_axis_tdata[0];
        item_in.pullup_k       = s_axis_tdata[1];
        item_in.sof_frame      = s_axis_tdata[12:2];
        item_in.dir_in         = s_axis_tdata[24];
        item_in.buf_len        = s_axis_tdata[40:25];
        item_in.event_kind     = s_axis_tdata[44:42];
        item_in.rx_count       = s_axis_tdata[55:45];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_packet        <= 10'd8;
            r_cfg.timeout_frames    <= 8'd100;
            r_cfg.settle_frames     <= 8'd100;
            r_cfg.reset_frames_full <= 9'd12;
            r_cfg.reset_frames_low  <= 9'd450;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_PACKET: r_cfg.max_packet        <= i_cfg_data;
                CFG_TIMEOUT:    r_cfg.timeout_frames    <= i_cfg_data[7:0];
                CFG_SETTLE:     r_cfg.settle_frames     <= i_cfg_data[7:0];
                CFG_RESET_FULL: r_cfg.reset_frames_full <= i_cfg_data[8:0];
                CFG_RESET_LOW:  r_cfg.reset_frames_low  <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item <= item_in;
        end
    end

    uhts_port_ctrl u_port (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_in_item),
        .i_cfg       (r_cfg),
        .o_xfer_tick (xfer_tick),
        .o_res       (port_res)
    );

    uhts_xfer_ctrl u_xfer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_in_item),
        .i_cfg       (r_cfg),
        .i_xfer_tick (xfer_tick),
        .o_res       (xfer_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= {4'd0,
                           port_res.frame_cnt,
                           port_res.low_speed,
                           port_res.bus_state,
                           port_res.port_event,
                           xfer_res.xfer_length,
                           xfer_res.result_code,
                           xfer_res.complete,
                           xfer_res.chunk_len,
                           xfer_res.chunk_offset,
                           xfer_res.data_toggle,
                           xfer_res.issue_cmd};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

### tb/usb_host_transaction_sequencer_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// usb_host_transaction_sequencer_top_test
// Self-checking bench for the USB host transfer sequencer. A short table of
// requests covers the field extremes, every opcode and the ignored cases, then
// random phases under several register settings drive attach, bus reset,
// frame ticks and whole transfers. Every result is compared field by field with
// its typed table row or with a cycle-free behavioral copy of the sequencer in the bench.
// ----------------------------------------------------------------------------
module usb_host_transaction_sequencer_top_test;
    import uhts_pkg::*;

    // opcodes and event kinds outside the package enums
    localparam logic [2:0] OP_SPARE_6   = 3'd6;
    localparam logic [2:0] OP_SPARE_7   = 3'd7;
    localparam logic [2:0] EV_FIRST_BAD = 3'd5;
    localparam logic [2:0] EV_LAST_BAD  = 3'd7;
    localparam int PHASE_ITEMS = 200;

    // request tdata, lowest field last
    typedef struct packed {
        logic [10:0] rx_count;
        logic [2:0]  event_kind;
        logic        dev_low_speed;
        logic [15:0] buf_len;
        logic        dir_in;
        logic [3:0]  ep_num;
        logic [6:0]  usb_addr;
        logic [10:0] sof_frame;
        logic        pullup_k;
        logic        pullup_present;
    } t_req_data;

    // result tdata, lowest field last
    typedef struct packed {
        logic [3:0]  fill;
        logic [31:0] frame_cnt;
        logic        low_speed;
        logic [1:0]  bus_state;
        logic [1:0]  port_event;
        logic [15:0] xfer_length;
        logic [1:0]  result_code;
        logic        complete;
        logic [9:0]  chunk_len;
        logic [15:0] chunk_offset;
        logic        data_toggle;
        logic        issue_cmd;
    } t_seq_out;

    // one row of the directed table
    typedef struct packed {
        logic [2:0] op;
        t_req_data  req;
        logic       typed;
        t_seq_out   res;
    } t_plan_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [9:0]  i_cfg_data = '0;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int mismatch_cnt = 0;

    t_seq_out  awaited_results[$];
    t_plan_row plan_q[$];

    // bench copy of the registers
    logic [9:0] mps_cfg = 10'd8;
    logic [7:0] tmo_cfg = 8'd100;
    logic [7:0] settle_cfg = 8'd100;
    logic [8:0] rst_full_cfg = 9'd12;
    logic [8:0] rst_low_cfg = 9'd450;

    // bench copy of the sequencer state
    logic        xf_busy = 1'b0;
    logic [2:0]  xf_kind = '0;
    logic        xf_toggle = 1'b1;
    logic [15:0] xf_in_left = '0;
    logic [15:0] xf_out_left = '0;
    logic [15:0] xf_pos = '0;
    logic [15:0] xf_done = '0;
    logic [7:0]  xf_tmo_left = '0;
    logic        xf_nak_pend = 1'b0;
    logic [7:0]  port_settle = '0;
    logic [8:0]  port_rst_left = '0;
    logic        port_low = 1'b0;
    logic [1:0]  bus_mode = BUS_QUIET;
    logic [31:0] frame_ext = '0;

    always #2 i_clk = ~i_clk;

    usb_host_transaction_sequencer_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // put the stored transaction on the bus
    task automatic issue_current(inout t_seq_out r);
        r.issue_cmd = 1'b1;
        r.data_toggle = xf_toggle;
        if (xf_kind[KIND_OUT]) begin
            r.chunk_offset = xf_pos;
            r.chunk_len = (xf_out_left > mps_cfg) ? mps_cfg : xf_out_left[9:0];
        end else if (xf_kind[KIND_SETUP]) begin
            r.chunk_offset = '0;
            r.chunk_len = SETUP_LEN;
        end
    endtask

    task automatic end_transfer(inout t_seq_out r, input logic [1:0] code);
        r.complete = 1'b1;
        r.result_code = code;
        r.xfer_length = xf_done;
        xf_busy = 1'b0;
        xf_nak_pend = 1'b0;
    endtask

    task automatic open_transfer(input logic [2:0] kind);
        xf_busy = 1'b1;
        xf_pos = '0;
        xf_done = '0;
        xf_tmo_left = tmo_cfg;
        xf_nak_pend = 1'b0;
        xf_kind = kind;
    endtask

    // advance the sequencer copy by one request and form its result
    task automatic step_sequencer(input logic [2:0] op, input t_req_data d,
                                  output t_seq_out r);
        logic [31:0] upper;
        logic [10:0] rx;
        logic [15:0] take;
        r = '0;
        case (op)
            OP_PORT_RESET: begin
                bus_mode = BUS_RESET;
                port_rst_left = rst_full_cfg;
                xf_busy = 1'b0;
                xf_nak_pend = 1'b0;
                xf_in_left = '0;
                xf_out_left = '0;
            end
            OP_PULLUP: begin
                port_rst_left = '0;
                bus_mode = BUS_QUIET;
                if (d.pullup_present || d.pullup_k) begin
                    port_settle = settle_cfg;
                    if (d.pullup_k) port_low = ~port_low;
                end else begin
                    port_settle = '0;
                    r.port_event = PEV_REMOVED;
                end
            end
            OP_FRAME: begin
                // extend the 11-bit frame number
                upper = {frame_ext[31:11], 11'd0};
                if (d.sof_frame < frame_ext[10:0]) upper = upper + 32'h800;
                frame_ext = upper | {21'd0, d.sof_frame};
                if (port_settle != 0) begin
                    port_settle = port_settle - 8'd1;
                    if (port_settle == 0) begin
                        bus_mode = BUS_RESET;
                        port_rst_left = port_low ? rst_low_cfg : rst_full_cfg;
                        r.port_event = PEV_ATTACHED;
                    end
                end else if (port_rst_left != 0) begin
                    port_rst_left = port_rst_left - 9'd1;
                    if (port_rst_left == 0) bus_mode = BUS_SOF;
                end else if (xf_busy) begin
                    if (xf_nak_pend) begin
                        issue_current(r);
                        if (xf_kind[KIND_IN]) begin
                            r.chunk_offset = xf_pos;
                            r.chunk_len = '0;
                        end
                        xf_nak_pend = 1'b0;
                        xf_tmo_left = tmo_cfg;
                    end else begin
                        xf_tmo_left = xf_tmo_left - 8'd1;
                        if (xf_tmo_left == 0) end_transfer(r, RES_TIMEOUT);
                    end
                end
            end
            OP_XFER: begin
                open_transfer(d.dir_in ? 3'(1 << KIND_IN) : 3'(1 << KIND_OUT));
                xf_toggle = 1'b1;
                xf_in_left = d.dir_in ? d.buf_len : 16'd0;
                xf_out_left = d.dir_in ? 16'd0 : d.buf_len;
                issue_current(r);
            end
            OP_SETUP: begin
                open_transfer(3'(1 << KIND_SETUP));
                xf_toggle = 1'b0;
                xf_in_left = '0;
                xf_out_left = '0;
                issue_current(r);
            end
            OP_RESULT: begin
                if (xf_busy) begin
                    if (d.event_kind == EV_STALL) begin
                        end_transfer(r, RES_STALLED);
                    end else if (d.event_kind == EV_ACK) begin
                        if (xf_kind[KIND_OUT] && xf_out_left > mps_cfg) begin
                            xf_out_left = xf_out_left - mps_cfg;
                            xf_pos = xf_pos + mps_cfg;
                            xf_done = xf_done + mps_cfg;
                            xf_toggle = ~xf_toggle;
                            issue_current(r);
                        end else begin
                            if (xf_kind[KIND_OUT]) xf_done = xf_done + xf_out_left;
                            end_transfer(r, RES_SUCCESS);
                        end
                    end else if (d.event_kind == EV_NAK) begin
                        if (!xf_kind[KIND_SETUP]) xf_nak_pend = 1'b1;
                    end else if ((d.event_kind == EV_DATA0 || d.event_kind == EV_DATA1)
                                 && xf_kind[KIND_IN]) begin
                        // strip crc, clamp to the buffer
                        rx = (d.rx_count > RX_COUNT_MAX) ? RX_COUNT_MAX : d.rx_count;
                        take = (rx >= CRC_BYTES) ? 16'(rx - CRC_BYTES) : 16'd0;
                        if (take > xf_in_left) take = xf_in_left;
                        r.chunk_offset = xf_pos;
                        r.chunk_len = take[9:0];
                        xf_pos = xf_pos + take;
                        xf_in_left = xf_in_left - take;
                        xf_done = xf_done + take;
                        if (xf_in_left == 0 || 32'(rx) < 32'(mps_cfg) + 32'd2) begin
                            end_transfer(r, RES_SUCCESS);
                        end else begin
                            xf_toggle = ~xf_toggle;
                            r.issue_cmd = 1'b1;
                            r.data_toggle = xf_toggle;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.bus_state = bus_mode;
        r.low_speed = port_low;
        r.frame_cnt = frame_ext;
    endtask

    function automatic bit same_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // compare one accepted result with the oldest prediction
    task automatic check_result(input t_seq_out got);
        t_seq_out want;
        bit ok;
        if (awaited_results.size() == 0) begin
            $display("%0t: result expected none got %h", $time, got);
            mismatch_cnt++;
        end else begin
            want = awaited_results.pop_front();
            ok = 1'b1;
            ok &= same_field("issue_cmd", 32'(want.issue_cmd), 32'(got.issue_cmd));
            ok &= same_field("data_toggle", 32'(want.data_toggle), 32'(got.data_toggle));
            ok &= same_field("chunk_offset", 32'(want.chunk_offset),
                             32'(got.chunk_offset));
            ok &= same_field("chunk_len", 32'(want.chunk_len), 32'(got.chunk_len));
            ok &= same_field("complete", 32'(want.complete), 32'(got.complete));
            ok &= same_field("result_code", 32'(want.result_code), 32'(got.result_code));
            ok &= same_field("xfer_length", 32'(want.xfer_length), 32'(got.xfer_length));
            ok &= same_field("port_event", 32'(want.port_event), 32'(got.port_event));
            ok &= same_field("bus_state", 32'(want.bus_state), 32'(got.bus_state));
            ok &= same_field("low_speed", 32'(want.low_speed), 32'(got.low_speed));
            ok &= same_field("frame_cnt", want.frame_cnt, got.frame_cnt);
            ok &= same_field("zero fill", 32'(want.fill), 32'(got.fill));
            if (!ok) mismatch_cnt++;
        end
    endtask

    // result handshake completes at the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_result(t_seq_out'(m_axis_tdata));
    end

    // result side stalls
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // drive one request until taken, then record its prediction
    task automatic put_request(input logic [2:0] op, input t_req_data d,
                               input logic typed, input t_seq_out typed_res);
        bit taken;
        t_seq_out pred;
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= d;
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        step_sequencer(op, d, pred);
        awaited_results.push_back(typed ? typed_res : pred);
    endtask

    // hold off requests until every result is back and the pipe is quiet
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [9:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [9:0] mps, input logic [7:0] tmo,
                                  input logic [7:0] stl, input logic [8:0] rfull,
                                  input logic [8:0] rlow);
        cfg_write(CFG_MAX_PACKET, mps);
        cfg_write(CFG_TIMEOUT, {2'd0, tmo});
        cfg_write(CFG_SETTLE, {2'd0, stl});
        cfg_write(CFG_RESET_FULL, {1'b0, rfull});
        cfg_write(CFG_RESET_LOW, {1'b0, rlow});
        i_cfg_we <= 1'b0;
        mps_cfg = mps;
        tmo_cfg = tmo;
        settle_cfg = stl;
        rst_full_cfg = rfull;
        rst_low_cfg = rlow;
    endtask

    function automatic t_req_data mk_req(input logic p, input logic k,
                                         input logic [10:0] sof, input logic [6:0] addr,
                                         input logic [3:0] ep, input logic dir,
                                         input logic [15:0] blen, input logic dlow,
                                         input logic [2:0] ev, input logic [10:0] rx);
        return '{rx_count: rx, event_kind: ev, dev_low_speed: dlow, buf_len: blen,
                 dir_in: dir, ep_num: ep, usb_addr: addr, sof_frame: sof,
                 pullup_k: k, pullup_present: p};
    endfunction

    function automatic t_seq_out mk_res(input logic iss, input logic tog,
                                        input logic [15:0] off, input logic [9:0] len,
                                        input logic cmp, input logic [1:0] code,
                                        input logic [15:0] xlen, input logic [1:0] pev,
                                        input logic [1:0] bus, input logic low,
                                        input logic [31:0] frame);
        return '{fill: 4'd0, frame_cnt: frame, low_speed: low, bus_state: bus,
                 port_event: pev, xfer_length: xlen, result_code: code, complete: cmp,
                 chunk_len: len, chunk_offset: off, data_toggle: tog, issue_cmd: iss};
    endfunction

    task automatic add_step(input logic [2:0] op, input t_req_data d, input logic typed,
                            input t_seq_out res);
        plan_q.push_back('{op: op, req: d, typed: typed, res: res});
    endtask

    // random request shaped by where the sequencer stands
    task automatic random_request(output logic [2:0] op, output t_req_data d);
        logic [63:0] raw;
        int pick;
        int r;
        int full;
        raw = {$urandom, $urandom};
        d = raw[55:0];
        pick = $urandom_range(99);
        full = int'(mps_cfg) + 2;
        op = OP_FRAME;
        if (pick < 10) begin
            // noise: ignored codes, resets, pullups, stray results
            case ($urandom_range(4))
                0: op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
                1: op = OP_PORT_RESET;
                2: op = OP_PULLUP;
                3: begin
                    op = OP_RESULT;
                    d.event_kind = 3'($urandom_range(EV_LAST_BAD, EV_FIRST_BAD));
                end
                default: op = OP_RESULT;
            endcase
        end else if ((port_settle != 0 || port_rst_left != 0) && pick < 60) begin
            op = OP_FRAME;
        end else if (!xf_busy) begin
            if (bus_mode == BUS_QUIET && port_settle == 0 && pick < 30) begin
                op = OP_PULLUP;
                d.pullup_present = 1'b1;
                d.pullup_k = ($urandom_range(3) == 0);
            end else if (pick < 40) begin
                op = OP_FRAME;
            end else begin
                op = ($urandom_range(4) == 0) ? OP_SETUP : OP_XFER;
                case ($urandom_range(9))
                    0: ;
                    1, 2: d.buf_len = 16'($urandom_range(255));
                    default: d.buf_len = 16'($urandom_range(4 * int'(mps_cfg) + 3));
                endcase
            end
        end else if (pick < 40) begin
            op = OP_FRAME;
        end else begin
            // answer the transaction in flight
            op = OP_RESULT;
            r = $urandom_range(99);
            if (xf_kind[KIND_IN]) begin
                if (r < 70) begin
                    d.event_kind = r[0] ? EV_DATA1 : EV_DATA0;
                    case ($urandom_range(3))
                        0, 1: d.rx_count = full[10:0];
                        2: d.rx_count = 11'($urandom_range(full - 1));
                        default: ;
                    endcase
                end else if (r < 85) begin
                    d.event_kind = EV_NAK;
                end else if (r < 92) begin
                    d.event_kind = EV_STALL;
                end else begin
                    d.event_kind = EV_ACK;
                end
            end else if (r < 75) begin
                d.event_kind = EV_ACK;
            end else if (r < 88) begin
                d.event_kind = EV_NAK;
            end else if (r < 95) begin
                d.event_kind = EV_STALL;
            end else begin
                d.event_kind = EV_DATA0;
            end
        end
        if (op == OP_FRAME && $urandom_range(9) != 0) d.sof_frame = frame_ext[10:0] + 11'd1;
    endtask

    // run limit
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // stimulus
    initial begin
        logic [2:0] op;
        t_req_data  d;
        t_seq_out   idle_rst;
        idle_rst = mk_res(0, 0, 0, 0, 0, RES_SUCCESS, 0, PEV_NONE, BUS_RESET, 0, 0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, reset register values
        add_step(OP_PORT_RESET, mk_req(0, 0, 0, 0, 0, 0, 0, 0, EV_STALL, 0), 1, idle_rst);
        add_step(OP_RESULT, mk_req(0, 0, 0, 0, 0, 0, 0, 0, EV_ACK, 0), 1, idle_rst);
        add_step(OP_SPARE_7, mk_req(1, 1, 0, 0, 0, 0, 0, 0, EV_ACK, 0), 1, idle_rst);
        add_step(OP_FRAME, mk_req(0, 0, 11'h7ff, 0, 0, 0, 0, 0, EV_STALL, 0), 1,
                 mk_res(0, 0, 0, 0, 0, RES_SUCCESS, 0, PEV_NONE, BUS_RESET, 0, 32'd2047));
        add_step(OP_FRAME, mk_req(0, 0, 0, 0, 0, 0, 0, 0, EV_STALL, 0), 1,
                 mk_res(0, 0, 0, 0, 0, RES_SUCCESS, 0, PEV_NONE, BUS_RESET, 0, 32'h800));
        add_step(OP_XFER, mk_req(0, 0, 0, 7'd127, 4'd15, 0, 0, 1, EV_STALL, 0), 1,
                 mk_res(1, 1, 0, 0, 0, RES_SUCCESS, 0, PEV_NONE, BUS_RESET, 0, 32'h800));
        add_step(OP_RESULT, mk_req(0, 0, 0, 0, 0, 0, 0, 0, EV_STALL, 0), 1,
                 mk_res(0, 0, 0, 0, 1, RES_STALLED, 0, PEV_NONE, BUS_RESET, 0, 32'h800));
        add_step(OP_SETUP, mk_req(0, 0, 0, 0, 0, 0, 0, 0, EV_STALL, 0), 1,
                 mk_res(1, 0, 0, SETUP_LEN, 0, RES_SUCCESS, 0, PEV_NONE, BUS_RESET, 0,
                        32'h800));
        // nak and data during a setup are dropped
        add_step(OP_RESULT, mk_req(0, 0, 0, 0, 0, 0, 0, 0, EV_NAK, 0), 1,
                 mk_res(0, 0, 0, 0, 0, RES_SUCCESS, 0, PEV_NONE, BUS_RESET, 0, 32'h800));
        add_step(OP_RESULT, mk_req(0, 0, 0, 0, 0, 0, 0, 0, EV_DATA1, 11'h7ff), 1,
                 mk_res(0, 0, 0, 0, 0, RES_SUCCESS, 0, PEV_NONE, BUS_RESET, 0, 32'h800));
        add_step(OP_RESULT, mk_req(0, 0, 0, 0, 0, 0, 0, 0, EV_ACK, 0), 1,
                 mk_res(0, 0, 0, 0, 1, RES_SUCCESS, 0, PEV_NONE, BUS_RESET, 0, 32'h800));
        // long in transfer, oversized and short receives
        add_step(OP_XFER, mk_req(0, 0, 0, 0, 0, 1, 16'hffff, 0, EV_STALL, 0), 0, '0);
        add_step(OP_RESULT, mk_req(0, 0, 0, 0, 0, 0, 0, 0, EV_DATA0, 11'd1025), 0, '0);
        add_step(OP_RESULT, mk_req(0, 0, 0, 0, 0, 0, 0, 0, EV_DATA1, 11'h7ff), 0, '0);
        add_step(OP_RESULT, mk_req(0, 0, 0, 0, 0, 0, 0, 0, EV_NAK, 0), 0, '0);
        add_step(OP_FRAME, mk_req(0, 0, 11'd1, 0, 0, 0, 0, 0, EV_STALL, 0), 0, '0);
        add_step(OP_RESULT, mk_req(0, 0, 0, 0, 0, 0, 0, 0, EV_LAST_BAD, 0), 0, '0);
        add_step(OP_RESULT, mk_req(0, 0, 0, 0, 0, 0, 0, 0, EV_DATA0, 0), 0, '0);
        // out transfer in three chunks
        add_step(OP_XFER, mk_req(0, 0, 0, 7'd5, 4'd1, 0, 16'd20, 0, EV_STALL, 0), 0, '0);
        add_step(OP_RESULT, mk_req(0, 0, 0, 0, 0, 0, 0, 0, EV_ACK, 0), 0, '0);
        add_step(OP_RESULT, mk_req(0, 0, 0, 0, 0, 0, 0, 0, EV_ACK, 0), 0, '0);
        add_step(OP_RESULT, mk_req(0, 0, 0, 0, 0, 0, 0, 0, EV_ACK, 0), 0, '0);
        // port reset drops a running transfer
        add_step(OP_XFER, mk_req(0, 0, 0, 7'd9, 4'd2, 0, 16'd9, 0, EV_STALL, 0), 0, '0);
        add_step(OP_PORT_RESET, mk_req(0, 0, 0, 0, 0, 0, 0, 0, EV_STALL, 0), 0, '0);
        // attach with k flips speed, then removal
        add_step(OP_PULLUP, mk_req(1, 1, 0, 0, 0, 0, 0, 0, EV_STALL, 0), 0, '0);
        add_step(OP_PULLUP, mk_req(0, 0, 0, 0, 0, 0, 0, 0, EV_STALL, 0), 0, '0);
        add_step(OP_SPARE_6, mk_req(0, 0, 0, 0, 0, 0, 0, 0, EV_STALL, 0), 0, '0);

        foreach (plan_q[i]) put_request(plan_q[i].op, plan_q[i].req, plan_q[i].typed,
                                        plan_q[i].res);

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            wait_drain();
            case (ph)
                0: apply_settings(10'd8, 8'd3, 8'd2, 9'd1, 9'd3);
                1: apply_settings(10'd1023, 8'd254, 8'd255, 9'd511, 9'd511);
                2: apply_settings(10'd1, 8'd1, 8'd1, 9'd1, 9'd1);
                3: apply_settings(10'd0, 8'd0, 8'd0, 9'd0, 9'd0);
                4: apply_settings(10'($urandom_range(1023, 1)), 8'($urandom_range(20, 1)),
                                  8'($urandom_range(20, 1)), 9'($urandom_range(20, 1)),
                                  9'($urandom_range(40, 1)));
                default: apply_settings(10'd64, 8'd10, 8'd4, 9'd2, 9'd6);
            endcase
            case (ph % 4)
                0: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
                1: begin snd_idle_pct = 46; rcv_idle_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_idle_pct = 46; end
                default: begin snd_idle_pct = 29; rcv_idle_pct = 29; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) wait_drain();
                random_request(op, d);
                put_request(op, d, 1'b0, '0);
            end
        end

        wait_drain();
        if (mismatch_cnt == 0 && awaited_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### files.f
design/uhts_pkg.sv
design/uhts_port_ctrl.sv
design/uhts_xfer_ctrl.sv
design/usb_host_transaction_sequencer_top.sv
tb/usb_host_transaction_sequencer_top_test.sv
